@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned AMOUNT_W  = 16;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 7'd64;
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd4096;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_MERGE   = 2'd2,
    MODE_REINIT  = 2'd3
  } mode_e;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_INIT      = 7'b0000010,
    ST_REQ       = 7'b0000100,
    ST_REL       = 7'b0001000,
    ST_MERGE     = 7'b0010000,
    ST_MERGE_END = 7'b0100000,
    ST_RESULT    = 7'b1000000
  } state_e;

endpackage

@@ rtl/first_fit_block_allocator.sv @@
// channel | direction | handshake              | beat
// in      | input     | in_valid_i/in_ready_o   | mode_i, block_index_i, amount_i
// out     | output    | out_valid_o/out_ready_i | status_o, granted_index_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// The table sits in one memory with a single read and a single write port and
// is walked one entry a cycle by request, merge and reinitialise; a release
// reads and writes back only its own entry, and a rejected one touches none.
// After reset a rebuild sweep over all entries runs with in_ready_o low.
// A finished result moves to the output register once it is free; a new beat is taken while it waits there.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS  = 64,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [IDX_W-1:0]     block_index_i,
  input  logic [AMOUNT_W-1:0]  amount_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [IDX_W-1:0]     granted_index_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_BLOCKS);
  localparam int unsigned LB  = LENGTH_BITS;
  localparam int unsigned GW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned SZW = (LB > SIZE_W) ? LB : SIZE_W;
  localparam int unsigned SW  = SZW + 1;
  localparam int unsigned CW  = (AW > COUNT_W) ? AW : COUNT_W;
  localparam logic [LB-1:0] LEN_MAX = '1;
  localparam logic [AW-1:0] LAST    = AW'(MAX_BLOCKS - 1);

  // entry word: present mark on top, free length below
  logic [LB:0] mem_q [MAX_BLOCKS];
  logic [LB:0] rd_q;

  state_e               state_q, state_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AMOUNT_W-1:0]  amount_q, amount_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic                 init_resp_q, init_resp_d;
  logic                 have_cur_q, have_cur_d;
  logic [AW-1:0]        cur_idx_q, cur_idx_d;
  logic [LB-1:0]        cur_len_q, cur_len_d;
  logic                 res_status_q, res_status_d;
  logic [IDX_W-1:0]     res_granted_q, res_granted_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q, out_status_d;
  logic [IDX_W-1:0]     out_granted_q, out_granted_d;
  logic [COUNT_W-1:0]   block_count_q;
  logic [SIZE_W-1:0]    block_size_q;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [LB:0]          wr_data;

  logic                 rd_pres;
  logic [LB-1:0]        rd_len;
  logic                 ptr_last;
  logic [GW-1:0]        idx_ext;
  logic [AW-1:0]        idx_addr;
  logic [GW-1:0]        ptr_ext;
  logic                 rel_reject;
  logic                 req_fit;
  logic [SW-1:0]        req_left;
  logic [LB-1:0]        rel_base;
  logic [SW-1:0]        rel_sum;
  logic [LB-1:0]        rel_len;
  logic [SW-1:0]        mrg_sum;
  logic                 mrg_fit;
  logic                 init_pres;
  logic [SZW-1:0]       size_ext;
  logic [LB-1:0]        init_len;
  logic                 out_free;

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_index_o = out_granted_q;

  assign rd_pres  = rd_q[LB];
  assign rd_len   = rd_q[LB-1:0];
  assign ptr_last = (ptr_q == LAST);
  assign idx_ext  = GW'(block_index_i);
  assign idx_addr = idx_ext[AW-1:0];
  assign ptr_ext  = GW'(ptr_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign rel_reject = ({1'b0, block_index_i} >= block_count_q)
                   || ({1'b0, idx_ext} >= (GW+1)'(MAX_BLOCKS))
                   || (amount_i == '0)
                   || (amount_i > block_size_q);

  assign req_fit  = rd_pres && (SW'(rd_len) >= SW'(amount_q));
  assign req_left = SW'(rd_len) - SW'(amount_q);

  assign rel_base = rd_pres ? rd_len : '0;
  assign rel_sum  = SW'(rel_base) + SW'(amount_q);
  assign rel_len  = (rel_sum > SW'(LEN_MAX)) ? LEN_MAX : rel_sum[LB-1:0];

  assign mrg_sum = SW'(cur_len_q) + SW'(rd_len);
  assign mrg_fit = mrg_sum <= SW'(block_size_q);

  assign init_pres = CW'(ptr_q) < CW'(cnt_q);
  assign size_ext  = SZW'(size_q);
  assign init_len  = (size_ext > SZW'(LEN_MAX)) ? LEN_MAX : size_ext[LB-1:0];

  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    amount_d      = amount_q;
    cnt_d         = cnt_q;
    size_d        = size_q;
    init_resp_d   = init_resp_q;
    have_cur_d    = have_cur_q;
    cur_idx_d     = cur_idx_q;
    cur_len_d     = cur_len_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_granted_d = out_granted_q;
    rd_en         = 1'b0;
    rd_addr       = ptr_q;
    wr_en         = 1'b0;
    wr_addr       = ptr_q;
    wr_data       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          amount_d      = amount_i;
          res_status_d  = 1'b0;
          res_granted_d = '0;
          case (mode_e'(mode_i))
            MODE_REQUEST: begin
              ptr_d   = '0;
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_REQ;
            end
            MODE_RELEASE: begin
              if (rel_reject) begin
                res_status_d = 1'b1;
                state_d      = ST_RESULT;
              end else begin
                ptr_d   = idx_addr;
                rd_en   = 1'b1;
                rd_addr = idx_addr;
                state_d = ST_REL;
              end
            end
            MODE_MERGE: begin
              ptr_d      = '0;
              have_cur_d = 1'b0;
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_d    = ST_MERGE;
            end
            MODE_REINIT: begin
              ptr_d       = '0;
              cnt_d       = block_count_q;
              size_d      = block_size_q;
              init_resp_d = 1'b1;
              state_d     = ST_INIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = init_pres ? {1'b1, init_len} : '0;
        ptr_d   = ptr_q + 1'b1;
        if (ptr_last) begin
          state_d = init_resp_q ? ST_RESULT : ST_IDLE;
        end
      end
      ST_REQ: begin
        if (req_fit) begin
          wr_en         = 1'b1;
          wr_data       = {(req_left[LB-1:0] != '0), req_left[LB-1:0]};
          res_granted_d = ptr_ext[IDX_W-1:0];
          state_d       = ST_RESULT;
        end else if (ptr_last) begin
          res_status_d = 1'b1;
          state_d      = ST_RESULT;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = ptr_q + 1'b1;
        end
      end
      ST_REL: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, rel_len};
        state_d = ST_RESULT;
      end
      ST_MERGE: begin
        if (rd_pres) begin
          if (!have_cur_q) begin
            have_cur_d = 1'b1;
            cur_idx_d  = ptr_q;
            cur_len_d  = rd_len;
          end else if (mrg_fit) begin
            cur_len_d = mrg_sum[LB-1:0];
            wr_en     = 1'b1;
            wr_data   = '0;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = cur_idx_q;
            wr_data   = {1'b1, cur_len_q};
            cur_idx_d = ptr_q;
            cur_len_d = rd_len;
          end
        end
        if (ptr_last) begin
          state_d = ST_MERGE_END;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = ptr_q + 1'b1;
        end
      end
      ST_MERGE_END: begin
        wr_en   = have_cur_q;
        wr_addr = cur_idx_q;
        wr_data = {1'b1, cur_len_q};
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_granted_d = res_granted_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      ptr_q         <= '0;
      cnt_q         <= BLOCK_COUNT_RST;
      size_q        <= BLOCK_SIZE_RST;
      init_resp_q   <= 1'b0;
      have_cur_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      block_count_q <= BLOCK_COUNT_RST;
      block_size_q  <= BLOCK_SIZE_RST;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      size_q      <= size_d;
      init_resp_q <= init_resp_d;
      have_cur_q  <= have_cur_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_BLOCK_COUNT: block_count_q <= cfg_data_i[COUNT_W-1:0];
          REG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[SIZE_W-1:0];
          default: begin
            block_count_q <= block_count_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    amount_q      <= amount_d;
    cur_idx_q     <= cur_idx_d;
    cur_len_q     <= cur_len_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    out_status_q  <= out_status_d;
    out_granted_q <= out_granted_d;
  end

endmodule
